### rtl/rcf_pkg.sv
package rcf_pkg;

    localparam int VALUE_WIDTH = 32;
    localparam int MAX_TERMS   = 48;
    localparam int LIMIT_WIDTH = 6;
    localparam int TERM_W      = $clog2(MAX_TERMS + 1);
    localparam int CNT_W       = $clog2(VALUE_WIDTH);

    // controller -> datapath
    typedef struct packed {
        logic load;   // take a new operand pair, start first division
        logic step;   // one restoring-division bit
        logic emit;   // register a term, move the pair on
    } t_rcf_cmd;

    // datapath -> controller
    typedef struct packed {
        logic den_zero;  // current denominator is zero
        logic div_last;  // division is on its final bit
        logic last;      // the term being formed ends the expansion
    } t_rcf_status;

endpackage

### rtl/rcf_datapath.sv
module rcf_datapath
    import rcf_pkg::*;
(
    input  logic                          i_clk,
    input  t_rcf_cmd                      i_cmd,
    input  logic signed [VALUE_WIDTH-1:0] i_numerator,
    input  logic signed [VALUE_WIDTH-1:0] i_denominator,
    input  logic        [LIMIT_WIDTH-1:0] i_term_limit,
    output t_rcf_status                   o_status,
    output logic signed [VALUE_WIDTH-1:0] o_term,
    output logic                          o_last_term
);

    localparam logic [VALUE_WIDTH-1:0] MIN_PATTERN = {1'b1, {(VALUE_WIDTH-1){1'b0}}};
    localparam logic [VALUE_WIDTH-1:0] MAX_MAG     = {1'b0, {(VALUE_WIDTH-1){1'b1}}};

    logic [VALUE_WIDTH-1:0] r_quo;   // dividend shifting out, quotient shifting in
    logic [VALUE_WIDTH-1:0] r_rem;
    logic [VALUE_WIDTH-1:0] r_den;
    logic                   r_neg;   // numerator sign after denominator fix-up
    logic [CNT_W-1:0]       r_cnt;
    logic [TERM_W-1:0]      r_nterm;
    logic [TERM_W-1:0]      r_lim;
    logic [VALUE_WIDTH-1:0] r_term;
    logic                   r_last;

    logic [VALUE_WIDTH-1:0] n_pmag;
    logic [VALUE_WIDTH-1:0] n_qmag;
    logic                   n_neg;
    logic [TERM_W-1:0]      n_lim;
    logic [VALUE_WIDTH-1:0] n_trial;
    logic                   n_ge;
    logic [VALUE_WIDTH-1:0] n_term;
    logic [VALUE_WIDTH-1:0] n_rnext;
    logic                   n_last;

    // saturating magnitudes of the operands, quotient sign and clamped term limit
    always_comb begin
        if (!i_numerator[VALUE_WIDTH-1]) begin
            n_pmag = i_numerator;
        end else if (i_numerator == MIN_PATTERN) begin
            n_pmag = MAX_MAG;
        end else begin
            n_pmag = VALUE_WIDTH'(0) - i_numerator;
        end
        if (!i_denominator[VALUE_WIDTH-1]) begin
            n_qmag = i_denominator;
        end else if (i_denominator == MIN_PATTERN) begin
            n_qmag = MAX_MAG;
        end else begin
            n_qmag = VALUE_WIDTH'(0) - i_denominator;
        end
        n_neg = i_numerator[VALUE_WIDTH-1] ^ i_denominator[VALUE_WIDTH-1];
        if (int'(i_term_limit) == 0 || int'(i_term_limit) > MAX_TERMS) begin
            n_lim = TERM_W'(MAX_TERMS);
        end else begin
            n_lim = TERM_W'(i_term_limit);
        end
    end

    // restoring division bit
    assign n_trial = {r_rem[VALUE_WIDTH-2:0], r_quo[VALUE_WIDTH-1]};
    assign n_ge    = (n_trial >= r_den);

    // floor correction for a negative numerator, and the last-term test
    always_comb begin
        if (r_neg && (r_rem != '0)) begin
            n_term  = ~r_quo;
            n_rnext = r_den - r_rem;
        end else if (r_neg) begin
            n_term  = VALUE_WIDTH'(0) - r_quo;
            n_rnext = '0;
        end else begin
            n_term  = r_quo;
            n_rnext = r_rem;
        end
        n_last = (n_rnext == '0) || ((int'(r_nterm) + 1) == int'(r_lim));
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_quo   <= n_pmag;
            r_den   <= n_qmag;
            r_neg   <= n_neg;
            r_rem   <= '0;
            r_cnt   <= CNT_W'(VALUE_WIDTH - 1);
            r_nterm <= '0;
            r_lim   <= n_lim;
        end else if (i_cmd.step) begin
            r_quo <= {r_quo[VALUE_WIDTH-2:0], n_ge};
            r_rem <= n_ge ? (n_trial - r_den) : n_trial;
            r_cnt <= r_cnt - CNT_W'(1);
        end else if (i_cmd.emit) begin
            r_term  <= n_term;
            r_last  <= n_last;
            r_quo   <= r_den;
            r_den   <= n_rnext;
            r_neg   <= 1'b0;
            r_rem   <= '0;
            r_cnt   <= CNT_W'(VALUE_WIDTH - 1);
            r_nterm <= r_nterm + TERM_W'(1);
        end
    end

    assign o_status.den_zero = (r_den == '0);
    assign o_status.div_last = (r_cnt == '0);
    assign o_status.last     = n_last;
    assign o_term            = r_term;
    assign o_last_term       = r_last;

endmodule

### rtl/rcf_ctrl.sv
module rcf_ctrl
    import rcf_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    input  t_rcf_status i_status,
    output t_rcf_cmd    o_cmd,
    output logic        busy,
    output logic        o_term_valid
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CHECK,
        ST_DIVIDE,
        ST_EMIT
    } t_state;

    t_state r_state;
    logic   r_valid;

    always_comb begin
        o_cmd      = '0;
        o_cmd.load = (r_state == ST_IDLE) && start;
        o_cmd.step = (r_state == ST_DIVIDE);
        o_cmd.emit = (r_state == ST_EMIT);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_valid <= 1'b0;
        end else begin
            r_valid <= 1'b0;
            unique case (r_state)
                ST_IDLE: begin
                    if (start) r_state <= ST_CHECK;
                end
                ST_CHECK: begin
                    r_state <= i_status.den_zero ? ST_IDLE : ST_DIVIDE;
                end
                ST_DIVIDE: begin
                    if (i_status.div_last) r_state <= ST_EMIT;
                end
                ST_EMIT: begin
                    r_valid <= 1'b1;
                    r_state <= i_status.last ? ST_IDLE : ST_DIVIDE;
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign busy         = (r_state != ST_IDLE);
    assign o_term_valid = r_valid;

endmodule

### rtl/rational_continued_fraction_top.sv
// Channel   Handshake                 Signals
// --------  ------------------------  ------------------------------------------
// input     start & !busy             i_numerator, i_denominator, i_term_limit
// result    o_term_valid (1 cycle)    o_term, o_last_term
//
// After a transfer, the check state tests the denominator, then each term is formed by the
// bit-serial restoring divider and registered by an emit state. One item at a time; a
// zero denominator returns to idle from the check state with no result. i_rst_n is
// synchronous, active low, and clears only control state. Results cannot be stalled; the
// strobe lasts one cycle and busy drops with the last term, so a new item can transfer
// while that term is shown.
module rational_continued_fraction_top
    import rcf_pkg::*;
(
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic signed [VALUE_WIDTH-1:0] i_numerator,
    input  logic signed [VALUE_WIDTH-1:0] i_denominator,
    input  logic        [LIMIT_WIDTH-1:0] i_term_limit,
    output logic                          o_term_valid,
    output logic signed [VALUE_WIDTH-1:0] o_term,
    output logic                          o_last_term
);

    t_rcf_cmd    cmd;
    t_rcf_status status;

    // sequencer: load, check, divide bit by bit, emit
    rcf_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .i_status     (status),
        .o_cmd        (cmd),
        .busy         (busy),
        .o_term_valid (o_term_valid)
    );

    // operand registers, shared divider, floor fix-up and term count
    rcf_datapath u_dp (
        .i_clk         (i_clk),
        .i_cmd         (cmd),
        .i_numerator   (i_numerator),
        .i_denominator (i_denominator),
        .i_term_limit  (i_term_limit),
        .o_status      (status),
        .o_term        (o_term),
        .o_last_term   (o_last_term)
    );

`ifndef ASSERT_OFF
    // a term only follows an emit command
    a_valid_after_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_term_valid |-> $past(cmd.emit))
        else $error("term strobe without emit");

    // a transfer makes the block busy
    a_busy_after_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("busy not raised after transfer");

    // final term frees the block
    a_idle_on_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_term_valid && o_last_term) |-> !busy)
        else $error("still busy after final term");

    // more terms follow a non-final term
    a_busy_on_more: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_term_valid && !o_last_term) |-> busy)
        else $error("idle after non-final term");
`endif

endmodule

### tb/rational_continued_fraction_top_tb.sv
module rational_continued_fraction_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import rcf_pkg::*;

    // Stimulus sizing
    localparam int N_DIRECTED   = 24;
    localparam int N_RANDOM     = 400;
    localparam int IDLE_PCT     = 35;          // sender idles this share of cycles
    localparam int QUIET_FIRST  = 150;         // random items in this window never idle
    localparam int QUIET_LAST   = 249;
    localparam int MAX_ERR_SHOW = 10;

    // Timing bounds for gaps, drain and the watchdog, from the divider and emit steps
    localparam int TERM_CYCLES  = VALUE_WIDTH + 1;
    localparam int MAX_GAP      = 2 * TERM_CYCLES + 4;
    localparam int DRAIN_CYCLES = 2 * TERM_CYCLES + 8;
    localparam int ITEM_WORST   = 2 + MAX_TERMS * TERM_CYCLES + MAX_GAP + 8;
    localparam int CYCLE_LIMIT  = 4 * (N_DIRECTED + N_RANDOM) * ITEM_WORST;

    // Largest magnitude of the symmetric signed range
    localparam longint MAX_MAG = (longint'(1) << (VALUE_WIDTH - 1)) - 1;

    typedef logic signed [VALUE_WIDTH-1:0] t_value;
    typedef logic        [LIMIT_WIDTH-1:0] t_limit;

    // One expected term on the result port
    typedef struct {
        t_value term;
        logic   last;
    } t_term_exp;

    // Directed row: operands, limit, and an optional hand-typed answer
    // (typed rows expect n_typed copies of typed_term, at most one here)
    typedef struct {
        t_value num;
        t_value den;
        t_limit lim;
        bit     typed;
        int     n_typed;
        t_value typed_term;
    } t_stim_row;

    logic   i_clk;
    logic   i_rst_n;
    logic   start;
    logic   busy;
    t_value i_numerator;
    t_value i_denominator;
    t_limit i_term_limit;
    logic   o_term_valid;
    t_value o_term;
    logic   o_last_term;

    t_term_exp expected_terms[$];
    t_stim_row directed_rows[N_DIRECTED];

    int cycle_count    = 0;
    int error_count    = 0;
    int terms_seen     = 0;
    int items_sent     = 0;
    int zero_den_items = 0;
    int cut_off_items  = 0;
    int longest_expand = 0;

    rational_continued_fraction_top DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_numerator  (i_numerator),
        .i_denominator(i_denominator),
        .i_term_limit (i_term_limit),
        .o_term_valid (o_term_valid),
        .o_term       (o_term),
        .o_last_term  (o_last_term)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
    end

    // Sign-extend an operand and clamp the one pattern outside the symmetric range.
    function automatic longint to_symmetric(t_value v);
        longint x;
        x = longint'(v);
        if (x < -MAX_MAG) x = -MAX_MAG;
        return x;
    endfunction

    // Euclidean expansion with floor division; queues one expectation per term.
    // last is set when the remainder hits zero or the term cap is reached.
    function automatic int expand_fraction(t_value num, t_value den, t_limit lim);
        longint    p, q, quo, rem;
        int        cap, n;
        t_term_exp e;
        p   = to_symmetric(num);
        q   = to_symmetric(den);
        cap = (lim == 0 || lim > MAX_TERMS) ? MAX_TERMS : int'(lim);
        n   = 0;
        if (q < 0) begin
            p = -p;
            q = -q;
        end
        while (q != 0 && n < cap) begin
            quo = p / q;
            rem = p % q;
            // C-style division truncates; pull back to floor
            if (rem < 0) begin
                quo -= 1;
                rem += q;
            end
            e.term = t_value'(quo);
            e.last = (rem == 0) || (n + 1 == cap);
            expected_terms.push_back(e);
            if (rem != 0 && n + 1 == cap) cut_off_items++;
            n++;
            p = q;
            q = rem;
        end
        return n;
    endfunction

    // Offer one item until it transfers, then queue what it should produce.
    // Idle cycles drop start for a cycle at random; any phase of the divider
    // can see them since the roll is made every cycle, busy or not.
    task automatic send_item(t_value num, t_value den, t_limit lim, bit may_idle,
                             bit typed, int n_typed, t_value typed_term);
        bit        go;
        int        n;
        t_term_exp e;
        if (may_idle && $urandom_range(0, 99) < 10) begin
            start <= 1'b0;
            repeat ($urandom_range(1, MAX_GAP)) @(posedge i_clk);
        end
        i_numerator   <= num;
        i_denominator <= den;
        i_term_limit  <= lim;
        do begin
            go = !may_idle || ($urandom_range(0, 99) >= IDLE_PCT);
            start <= go;
            @(posedge i_clk);
        end while (!(go && busy === 1'b0));

        if (typed) begin
            for (int k = 0; k < n_typed; k++) begin
                e.term = typed_term;
                e.last = (k == n_typed - 1);
                expected_terms.push_back(e);
            end
            n = n_typed;
        end else begin
            n = expand_fraction(num, den, lim);
        end
        items_sent++;
        if (den == 0) zero_den_items++;
        if (n > longest_expand) longest_expand = n;
    endtask

    // Random operand mix: raw bit patterns, small ratios, Fibonacci pairs
    // (longest expansions), range corners, zero denominators, near-multiples.
    task automatic random_operands(output t_value num, output t_value den, output t_limit lim);
        int     pick;
        int     k;
        longint f_lo, f_hi, f_nx, m;
        t_value tmp;
        t_value corners[6];
        corners = '{'0, 1, -1, t_value'(MAX_MAG), t_value'(-MAX_MAG),
                    {1'b1, {(VALUE_WIDTH-1){1'b0}}}};
        pick = $urandom_range(0, 99);
        num  = t_value'($urandom);
        den  = t_value'($urandom);
        if (pick < 25) begin
            // full-width random patterns as drawn
        end else if (pick < 50) begin
            num = t_value'(int'($urandom_range(0, 2000)) - 1000);
            den = t_value'(int'($urandom_range(0, 100)) - 50);
        end else if (pick < 70) begin
            k    = $urandom_range(10, 45);
            f_lo = 0;
            f_hi = 1;
            repeat (k) begin
                f_nx = f_lo + f_hi;
                f_lo = f_hi;
                f_hi = f_nx;
            end
            num = t_value'(f_hi);
            den = t_value'(f_lo);
            if ($urandom_range(0, 1)) num = -num;
            if ($urandom_range(0, 1)) den = -den;
            if ($urandom_range(0, 3) == 0) begin
                tmp = num;
                num = den;
                den = tmp;
            end
        end else if (pick < 80) begin
            num = corners[$urandom_range(0, 5)];
            den = corners[$urandom_range(0, 5)];
        end else if (pick < 88) begin
            den = '0;
        end else begin
            m   = longint'(int'($urandom_range(0, 2000)) - 1000);
            den = t_value'(int'($urandom_range(1, 65535)));
            if ($urandom_range(0, 1)) den = -den;
            num = t_value'(m * longint'(den) + longint'(int'($urandom_range(0, 6)) - 3));
        end
        lim = $urandom_range(0, 1) ? t_limit'(0)
                                   : t_limit'($urandom_range(0, (1 << LIMIT_WIDTH) - 1));
    endtask

    // Result checker: every strobe pops the oldest expectation.
    always @(posedge i_clk) begin : term_check
        t_term_exp want;
        if (i_rst_n === 1'b1 && o_term_valid === 1'b1) begin
            terms_seen++;
            if (expected_terms.size() == 0) begin
                error_count++;
                if (error_count <= MAX_ERR_SHOW)
                    $display("cycle %0d: unexpected term %0d (last %0b)",
                             cycle_count, o_term, o_last_term);
            end else begin
                want = expected_terms.pop_front();
                if (o_term !== want.term || o_last_term !== want.last) begin
                    error_count++;
                    if (error_count <= MAX_ERR_SHOW)
                        $display("cycle %0d: term exp %0d last %0b, got %0d last %0b",
                                 cycle_count, want.term, want.last, o_term, o_last_term);
                end
            end
        end
    end

    // Watchdog
    initial begin
        repeat (CYCLE_LIMIT) @(posedge i_clk);
        $display("no finish within %0d cycles, %0d terms still due",
                 CYCLE_LIMIT, expected_terms.size());
        $display("*** FAILED ***");
        $finish;
    end

    initial begin
        t_value num, den;
        t_limit lim;

        // num, den, lim, typed, n_typed, typed_term
        directed_rows = '{
            '{7,                 1,                 0,  1'b1, 1, 7},
            '{0,                 5,                 0,  1'b1, 1, 0},
            '{0,                 0,                 0,  1'b1, 0, 0},   // zero denominator
            '{12345,             0,                 0,  1'b1, 0, 0},
            '{-9,                0,                 3,  1'b1, 0, 0},
            '{2147483647,        1,                 0,  1'b1, 1, 2147483647},
            '{32'sh8000_0000,    1,                 0,  1'b1, 1, -2147483647}, // clamped
            '{-2147483647,       1,                 0,  1'b1, 1, -2147483647},
            '{5,                 -1,                0,  1'b1, 1, -5},  // sign moved up
            '{0,                 -5,                0,  1'b1, 1, 0},
            '{-2147483647,       -2147483647,       0,  1'b1, 1, 1},
            '{32'sh8000_0000,    32'sh8000_0000,    0,  1'b1, 1, 1},
            '{1836311903,        1134903170,        1,  1'b1, 1, 1},   // cut after one
            '{1,                 32'sh8000_0000,    0,  1'b0, 0, 0},
            '{1,                 2147483647,        0,  1'b0, 0, 0},
            '{2147483647,        2147483646,        0,  1'b0, 0, 0},
            '{-7,                3,                 0,  1'b0, 0, 0},   // floor, not trunc
            '{7,                 -3,                0,  1'b0, 0, 0},
            '{355,               113,               2,  1'b0, 0, 0},   // cut-off expansion
            '{1836311903,        1134903170,        0,  1'b0, 0, 0},   // longest expansion
            '{1836311903,        1134903170,        48, 1'b0, 0, 0},
            '{1836311903,        1134903170,        63, 1'b0, 0, 0},   // limit above cap
            '{-1134903170,       1836311903,        49, 1'b0, 0, 0},
            '{2147483647,        -2,                5,  1'b0, 0, 0}
        };

        // Every input known from time zero; reset held low, then released before the first item.
        i_rst_n       <= 1'b0;
        start         <= 1'b0;
        i_numerator   <= '0;
        i_denominator <= '0;
        i_term_limit  <= '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_rows[r]) begin
            send_item(directed_rows[r].num, directed_rows[r].den, directed_rows[r].lim,
                      1'b1, directed_rows[r].typed, directed_rows[r].n_typed,
                      directed_rows[r].typed_term);
        end

        for (int r = 0; r < N_RANDOM; r++) begin
            random_operands(num, den, lim);
            send_item(num, den, lim, !(r >= QUIET_FIRST && r <= QUIET_LAST), 1'b0, 0, '0);
        end
        start <= 1'b0;

        // Drain: all terms in, then room for any stray strobe.
        while (expected_terms.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("coverage: %0d transfers (%0d directed, %0d random), %0d terms checked",
                 items_sent, N_DIRECTED, N_RANDOM, terms_seen);
        $display("coverage: %0d zero-denominator items, %0d cut by limit, longest %0d terms",
                 zero_den_items, cut_off_items, longest_expand);
        if (error_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("%0d mismatches", error_count);
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

### rational_continued_fraction_top.f
rtl/rcf_pkg.sv
rtl/rcf_datapath.sv
rtl/rcf_ctrl.sv
rtl/rational_continued_fraction_top.sv
tb/rational_continued_fraction_top_tb.sv
